[hw/rtl/cms_pkg.sv]
// cms_pkg: shared constants, types and helpers of the cube map sampler
// depends on nothing
package cms_pkg;

  localparam int FACE_DIM   = 64;
  localparam int DIR_BITS   = 16;
  localparam int IDX_BITS   = (FACE_DIM > 1) ? $clog2(FACE_DIM) : 1;
  localparam int TEXELS     = 6 * FACE_DIM * FACE_DIM;
  localparam int ADDR_BITS  = $clog2(TEXELS);
  localparam int SUM_BITS   = DIR_BITS + 1;
  localparam int DEN_BITS   = DIR_BITS + 1;
  localparam int NUM_BITS   = SUM_BITS + IDX_BITS;
  localparam int WORD_BITS  = 32;

  typedef enum logic [2:0] {
    REG_FACE_WIDTH  = 3'd0,
    REG_FACE_HEIGHT = 3'd1,
    REG_RED_MASK    = 3'd2,
    REG_RED_SHIFT   = 3'd3,
    REG_GREEN_MASK  = 3'd4,
    REG_GREEN_SHIFT = 3'd5,
    REG_BLUE_MASK   = 3'd6,
    REG_BLUE_SHIFT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [2:0]          face;
    logic                zero;
    logic                load_ok;
    logic [2:0]          load_face;
    logic [5:0]          load_col;
    logic [5:0]          load_row;
    logic [WORD_BITS-1:0] load_word;
    logic [DEN_BITS-1:0] den;
  } meta_t;

  function automatic logic [IDX_BITS-1:0] size_m1(input logic [6:0] r);
    logic [31:0] e;
    e = 32'(r);
    if (e == 32'd0) e = 32'd1;
    if (e > 32'(FACE_DIM)) e = 32'(FACE_DIM);
    return IDX_BITS'(e - 32'd1);
  endfunction

  function automatic logic [7:0] unpack(input logic [31:0] word, input logic [31:0] mask,
                                        input logic [4:0] shift);
    logic [31:0] c;
    c = (word & mask) >> shift;
    return (c > 32'd255) ? 8'd255 : c[7:0];
  endfunction

endpackage

[hw/rtl/cms_ram.sv]
// cms_ram: generic single port ram with registered read
// depends on nothing
module cms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hw/rtl/cms_front.sv]
// cms_front: face selection and numerator/denominator stages
// depends on cms_pkg
module cms_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         op,
  input  logic [2:0]                   load_face,
  input  logic [5:0]                   load_col,
  input  logic [5:0]                   load_row,
  input  logic [31:0]                  load_word,
  input  logic signed [cms_pkg::DIR_BITS-1:0] dir_u,
  input  logic signed [cms_pkg::DIR_BITS-1:0] dir_v,
  input  logic signed [cms_pkg::DIR_BITS-1:0] dir_w,
  input  logic [cms_pkg::IDX_BITS-1:0] wm1,
  input  logic [cms_pkg::IDX_BITS-1:0] hm1,
  output cms_pkg::meta_t               meta_o,
  output logic [cms_pkg::NUM_BITS-1:0] num_c,
  output logic [cms_pkg::NUM_BITS-1:0] num_r
);
  import cms_pkg::*;

  logic [DIR_BITS-1:0] au, av, aw, m_sel;
  logic signed [SUM_BITS-1:0] eu, ev, ew, s_sel, t_sel;
  logic [2:0] f_sel;
  meta_t m_in, s1_meta;
  logic signed [SUM_BITS-1:0] s1_s, s1_t;
  logic [DIR_BITS-1:0] s1_m;
  logic [SUM_BITS-1:0] sum_s, sum_t;

  always_comb begin
    eu = SUM_BITS'(dir_u);
    ev = SUM_BITS'(dir_v);
    ew = SUM_BITS'(dir_w);
    au = dir_u[DIR_BITS-1] ? DIR_BITS'(-eu) : DIR_BITS'(eu);
    av = dir_v[DIR_BITS-1] ? DIR_BITS'(-ev) : DIR_BITS'(ev);
    aw = dir_w[DIR_BITS-1] ? DIR_BITS'(-ew) : DIR_BITS'(ew);
    if (au >= av && au >= aw) begin
      m_sel = au;
      t_sel = -ev;
      if (!dir_u[DIR_BITS-1]) begin
        f_sel = 3'd0; s_sel = -ew;
      end else begin
        f_sel = 3'd1; s_sel = ew;
      end
    end else if (av >= aw) begin
      m_sel = av;
      s_sel = eu;
      if (!dir_v[DIR_BITS-1]) begin
        f_sel = 3'd2; t_sel = ew;
      end else begin
        f_sel = 3'd3; t_sel = -ew;
      end
    end else begin
      m_sel = aw;
      t_sel = -ev;
      if (!dir_w[DIR_BITS-1]) begin
        f_sel = 3'd4; s_sel = eu;
      end else begin
        f_sel = 3'd5; s_sel = -eu;
      end
    end
    m_in.valid     = in_valid;
    m_in.op        = op_t'(op);
    m_in.face      = f_sel;
    m_in.zero      = (m_sel == '0);
    m_in.load_ok   = (load_face < 3'd6) && (32'(load_col) < 32'(FACE_DIM))
                     && (32'(load_row) < 32'(FACE_DIM));
    m_in.load_face = load_face;
    m_in.load_col  = load_col;
    m_in.load_row  = load_row;
    m_in.load_word = load_word;
    m_in.den       = {m_sel, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_meta.valid <= 1'b0;
      meta_o.valid  <= 1'b0;
    end else if (en) begin
      s1_meta <= m_in;
      s1_s    <= s_sel;
      s1_t    <= t_sel;
      s1_m    <= m_sel;
      meta_o  <= s1_meta;
      num_c   <= NUM_BITS'(sum_s) * NUM_BITS'(wm1);
      num_r   <= NUM_BITS'(sum_t) * NUM_BITS'(hm1);
    end
  end

  assign sum_s = SUM_BITS'(s1_s + $signed({1'b0, s1_m}));
  assign sum_t = SUM_BITS'(s1_t + $signed({1'b0, s1_m}));

endmodule

[hw/rtl/cms_div.sv]
// cms_div: pipelined restoring divider, one quotient bit per stage, two lanes
// depends on cms_pkg
module cms_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  cms_pkg::meta_t               meta_i,
  input  logic [cms_pkg::NUM_BITS-1:0] num_c,
  input  logic [cms_pkg::NUM_BITS-1:0] num_r,
  output cms_pkg::meta_t               meta_o,
  output logic [cms_pkg::IDX_BITS-1:0] q_c,
  output logic [cms_pkg::IDX_BITS-1:0] q_r,
  output logic [cms_pkg::NUM_BITS-1:0] rem_c,
  output logic [cms_pkg::NUM_BITS-1:0] rem_r
);
  import cms_pkg::*;

  meta_t               mi  [IDX_BITS];
  logic [NUM_BITS-1:0] ci  [IDX_BITS];
  logic [NUM_BITS-1:0] ri  [IDX_BITS];
  logic [IDX_BITS-1:0] qci [IDX_BITS];
  logic [IDX_BITS-1:0] qri [IDX_BITS];
  logic [NUM_BITS-1:0] dsh [IDX_BITS];
  logic                bc  [IDX_BITS];
  logic                br  [IDX_BITS];
  meta_t               mq  [IDX_BITS];
  logic [NUM_BITS-1:0] rc  [IDX_BITS];
  logic [NUM_BITS-1:0] rr  [IDX_BITS];
  logic [IDX_BITS-1:0] qc  [IDX_BITS];
  logic [IDX_BITS-1:0] qr  [IDX_BITS];

  always_comb begin
    mi[0]  = meta_i;
    ci[0]  = num_c;
    ri[0]  = num_r;
    qci[0] = '0;
    qri[0] = '0;
    for (int k = 1; k < IDX_BITS; k++) begin
      mi[k]  = mq[k-1];
      ci[k]  = rc[k-1];
      ri[k]  = rr[k-1];
      qci[k] = qc[k-1];
      qri[k] = qr[k-1];
    end
    for (int k = 0; k < IDX_BITS; k++) begin
      dsh[k] = NUM_BITS'(mi[k].den) << (IDX_BITS - 1 - k);
      bc[k]  = (ci[k] >= dsh[k]);
      br[k]  = (ri[k] >= dsh[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < IDX_BITS; k++) begin
        mq[k].valid <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < IDX_BITS; k++) begin
        mq[k] <= mi[k];
        rc[k] <= bc[k] ? ci[k] - dsh[k] : ci[k];
        rr[k] <= br[k] ? ri[k] - dsh[k] : ri[k];
        qc[k] <= qci[k] | (IDX_BITS'(bc[k]) << (IDX_BITS - 1 - k));
        qr[k] <= qri[k] | (IDX_BITS'(br[k]) << (IDX_BITS - 1 - k));
      end
    end
  end

  assign meta_o = mq[IDX_BITS-1];
  assign q_c    = qc[IDX_BITS-1];
  assign q_r    = qr[IDX_BITS-1];
  assign rem_c  = rc[IDX_BITS-1];
  assign rem_r  = rr[IDX_BITS-1];

endmodule

[hw/rtl/cube_map_nearest_sampler.sv]
// cube_map_nearest_sampler: top level, config registers, rounding, texel store, unpack
// depends on cms_pkg, cms_front, cms_div, cms_ram
// pipeline: 2 front stages, IDX_BITS divider stages (6), round, ram read, output
// throughput: one request per cycle, loads and samples alike; the texel ram port is
// shared in order by loads and sample reads; the whole pipe holds while a result waits
// reset: config registers take their defaults, pipeline valid bits clear, texel store
// contents are undefined until loaded
module cube_map_nearest_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [2:0]  load_face,
  input  logic [5:0]  load_col,
  input  logic [5:0]  load_row,
  input  logic [31:0] load_word,
  input  logic signed [cms_pkg::DIR_BITS-1:0] dir_u,
  input  logic signed [cms_pkg::DIR_BITS-1:0] dir_v,
  input  logic signed [cms_pkg::DIR_BITS-1:0] dir_w,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  face,
  output logic [5:0]  texel_col,
  output logic [5:0]  texel_row,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  logic        cfg_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cms_pkg::*;

  logic [6:0]  face_width, face_height;
  logic [31:0] red_mask, green_mask, blue_mask;
  logic [4:0]  red_shift, green_shift, blue_shift;
  logic        adv;
  logic [IDX_BITS-1:0] wm1, hm1;
  meta_t       f_meta, d_meta, x_meta, r_meta;
  logic [NUM_BITS-1:0] num_c, num_r, rem_c, rem_r;
  logic [IDX_BITS-1:0] q_c, q_r, col_next, row_next, x_col, x_row, r_col, r_row;
  logic [ADDR_BITS-1:0] addr;
  logic        ram_we, ram_re;
  logic [31:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_width  <= 7'd64;
      face_height <= 7'd64;
      red_mask    <= 32'h00ff_0000;
      red_shift   <= 5'd16;
      green_mask  <= 32'h0000_ff00;
      green_shift <= 5'd8;
      blue_mask   <= 32'h0000_00ff;
      blue_shift  <= 5'd0;
    end else if (cfg_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FACE_WIDTH:  face_width  <= cfg_data[6:0];
        REG_FACE_HEIGHT: face_height <= cfg_data[6:0];
        REG_RED_MASK:    red_mask    <= cfg_data;
        REG_RED_SHIFT:   red_shift   <= cfg_data[4:0];
        REG_GREEN_MASK:  green_mask  <= cfg_data;
        REG_GREEN_SHIFT: green_shift <= cfg_data[4:0];
        REG_BLUE_MASK:   blue_mask   <= cfg_data;
        REG_BLUE_SHIFT:  blue_shift  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign wm1      = size_m1(face_width);
  assign hm1      = size_m1(face_height);
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  cms_front u_front (
    .clk, .rst, .en(adv), .in_valid, .op, .load_face, .load_col, .load_row, .load_word,
    .dir_u, .dir_v, .dir_w, .wm1, .hm1, .meta_o(f_meta), .num_c, .num_r
  );

  cms_div u_div (
    .clk, .rst, .en(adv), .meta_i(f_meta), .num_c, .num_r,
    .meta_o(d_meta), .q_c, .q_r, .rem_c, .rem_r
  );

  function automatic logic [IDX_BITS-1:0] round_q(input logic [IDX_BITS-1:0] q,
      input logic [NUM_BITS-1:0] r, input logic [DEN_BITS-1:0] den,
      input logic [IDX_BITS-1:0] lim);
    logic [NUM_BITS:0]   two_r;
    logic [NUM_BITS:0]   d;
    logic                up;
    logic [IDX_BITS:0]   qq;
    two_r = {r, 1'b0};
    d     = (NUM_BITS+1)'(den);
    up    = (two_r > d) || (two_r == d && q[0]);
    qq    = (IDX_BITS+1)'(q) + (IDX_BITS+1)'(up);
    if (qq > (IDX_BITS+1)'(lim)) qq = (IDX_BITS+1)'(lim);
    return qq[IDX_BITS-1:0];
  endfunction

  assign col_next = d_meta.zero ? '0 : round_q(q_c, rem_c, d_meta.den, wm1);
  assign row_next = d_meta.zero ? '0 : round_q(q_r, rem_r, d_meta.den, hm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_meta.valid <= 1'b0;
      r_meta.valid <= 1'b0;
      out_valid    <= 1'b0;
    end else if (adv) begin
      x_meta    <= d_meta;
      x_col     <= col_next;
      x_row     <= row_next;
      r_meta    <= x_meta;
      r_col     <= x_col;
      r_row     <= x_row;
      out_valid <= r_meta.valid && (r_meta.op == OP_SAMPLE);
      face      <= r_meta.face;
      texel_col <= 6'(r_col);
      texel_row <= 6'(r_row);
      red       <= unpack(rdata, red_mask, red_shift);
      green     <= unpack(rdata, green_mask, green_shift);
      blue      <= unpack(rdata, blue_mask, blue_shift);
    end
  end

  always_comb begin
    if (x_meta.op == OP_SAMPLE) begin
      addr = ADDR_BITS'(32'(x_meta.face) * FACE_DIM * FACE_DIM
             + 32'(x_row) * FACE_DIM + 32'(x_col));
    end else begin
      addr = ADDR_BITS'(32'(x_meta.load_face) * FACE_DIM * FACE_DIM
             + 32'(x_meta.load_row) * FACE_DIM + 32'(x_meta.load_col));
    end
  end

  assign ram_re = adv && x_meta.valid && (x_meta.op == OP_SAMPLE);
  assign ram_we = adv && x_meta.valid && (x_meta.op == OP_LOAD) && x_meta.load_ok;

  cms_ram #(.WIDTH(WORD_BITS), .DEPTH(TEXELS)) u_ram (
    .clk, .we(ram_we), .re(ram_re), .addr, .wdata(x_meta.load_word), .rdata
  );

`ifndef SYNTHESIS
  a_port_excl: assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("texel ram read and write in one cycle");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(r_meta.valid && r_meta.op == OP_SAMPLE))
    else $error("result without a sample request");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (x_meta.valid && x_meta.zero) |-> (x_col == '0 && x_row == '0 && x_meta.face == 3'd0))
    else $error("zero direction not mapped to texel 0,0 of +x");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    x_meta.valid |-> (x_col <= wm1 && x_row <= hm1))
    else $error("texel index beyond face size");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(rdata))
    else $error("ram data lost while result stalled");
`endif

endmodule
